### src/b64enc_pkg.sv
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
package b64enc_pkg;

  localparam logic [6:0] PadChar = 7'd61;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_beat_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       group_end;
    logic       message_end;
  } out_beat_t;

  // One complete 24-bit group: bytes held minus one (0..2) and the end-of-message flag.
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  nbytes_m1;
    logic        fin;
  } group_t;

  // Map a sextet to its ASCII character of the standard alphabet.
  function automatic logic [6:0] sextet_to_ascii(input logic [5:0] s);
    logic [7:0] w;
    w = {2'b00, s};
    if (s < 6'd26) begin
      sextet_to_ascii = 7'(w + 8'd65);
    end else if (s < 6'd52) begin
      sextet_to_ascii = 7'(w + 8'd71);
    end else if (s < 6'd62) begin
      sextet_to_ascii = 7'(w - 8'd4);
    end else if (s == 6'd62) begin
      sextet_to_ascii = 7'd43;
    end else begin
      sextet_to_ascii = 7'd47;
    end
  endfunction

endpackage

### src/b64enc_front.sv
// Front part: buffers pending bytes and assembles complete groups.
module b64enc_front
  import b64enc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_beat_t in_beat_i,
  output logic     in_accept_o,
  input  logic     q_full_i,
  output logic     push_o,
  output group_t   push_group_o
);

  logic [7:0] pend0_q, pend0_d;
  logic [7:0] pend1_q, pend1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       cnt_two;

  assign in_accept_o = in_valid_i && !q_full_i;
  // A stray count of three behaves as two.
  assign cnt_two     = cnt_q[1];

  always_comb begin
    pend0_d = pend0_q;
    pend1_d = pend1_q;
    cnt_d   = cnt_q;
    push_o  = 1'b0;
    push_group_o.fin       = in_beat_i.final_byte;
    push_group_o.nbytes_m1 = cnt_two ? 2'd2 : cnt_q;
    unique case ({cnt_two, cnt_q[0]})
      2'b00:   push_group_o.bits = {in_beat_i.data_byte, 16'h0000};
      2'b01:   push_group_o.bits = {pend0_q, in_beat_i.data_byte, 8'h00};
      default: push_group_o.bits = {pend0_q, pend1_q, in_beat_i.data_byte};
    endcase
    if (in_accept_o) begin
      if (!cnt_two && !in_beat_i.final_byte) begin
        // Hold the byte until its group closes.
        if (cnt_q[0]) begin
          pend1_d = in_beat_i.data_byte;
        end else begin
          pend0_d = in_beat_i.data_byte;
        end
        cnt_d = cnt_q + 2'd1;
      end else begin
        push_o = 1'b1;
        cnt_d  = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend0_q <= pend0_d;
    pend1_q <= pend1_d;
  end

endmodule

### src/b64enc_queue.sv
// Two-entry group queue between the front and back parts.
module b64enc_queue
  import b64enc_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  group_t push_group_i,
  input  logic   pop_i,
  output group_t pop_group_o,
  output logic   full_o,
  output logic   empty_o
);

  group_t     slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] fill_q;

  assign full_o      = fill_q[1];
  assign empty_o     = (fill_q == 2'd0);
  assign pop_group_o = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_group_i;
    end
  end

endmodule

### src/b64enc_back.sv
// Back part: walks a group one character per cycle into the output register while the output is not stalled.
module b64enc_back
  import b64enc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_empty_i,
  input  group_t    q_group_i,
  output logic      pop_o,
  output logic      out_valid_o,
  output out_beat_t out_beat_o,
  input  logic      out_stall_i
);

  group_t     grp_q;
  logic       busy_q, busy_d;
  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  out_beat_t  out_q, out_d;
  logic       load_out;
  logic [5:0] sextet;
  logic       is_pad;

  assign load_out = !out_valid_q || !out_stall_i;

  always_comb begin
    case (idx_q)
      2'd0:    sextet = grp_q.bits[23:18];
      2'd1:    sextet = grp_q.bits[17:12];
      2'd2:    sextet = grp_q.bits[11:6];
      default: sextet = grp_q.bits[5:0];
    endcase
    // Characters carried = bytes + 1; the rest pad.
    is_pad = ({1'b0, idx_q} > ({1'b0, grp_q.nbytes_m1} + 3'd1));
  end

  always_comb begin
    out_d.char_code   = is_pad ? PadChar : sextet_to_ascii(sextet);
    out_d.group_end   = (idx_q == 2'd3);
    out_d.message_end = (idx_q == 2'd3) && grp_q.fin;
    out_valid_d       = load_out ? busy_q : out_valid_q;
    idx_d             = idx_q;
    busy_d            = busy_q;
    if (busy_q && load_out) begin
      idx_d = idx_q + 2'd1;
      if (idx_q == 2'd3) begin
        busy_d = 1'b0;
      end
    end
    // Take the next group as the current one leaves.
    pop_o = !q_empty_i && (!busy_q || (load_out && idx_q == 2'd3));
    if (pop_o) begin
      busy_d = 1'b1;
      idx_d  = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      grp_q <= q_group_i;
    end
    if (busy_q && load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

### src/base64_stream_encoder_core.sv
// Top level of the base64 stream encoder: front, group queue and back.
//
//  Channel | Direction | Handshake             | Beat
//  --------+-----------+-----------------------+-------------------------------------
//  in      | input     | in_valid_i/in_stall_o | in_beat_t: data_byte, final_byte
//  out     | output    | out_valid_o/out_stall_i | out_beat_t: char_code, group_end,
//          |           |                       |   message_end
//
// The front takes one byte beat per cycle while the two-entry group queue has room;
// a byte that closes a group enters the queue in that cycle.
// The back emits one character per cycle while out is not stalled, four per group, so the
// single output port sets the sustained rate.
// A closing byte reaches out through the queue slot, the back's group register and the output register.
// Reset clears the pending count, queue pointers and fill count, the back's busy flag and index, and output valid.
// A stall on out holds the output register; the queue then fills and in stalls.
module base64_stream_encoder_core
  import b64enc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  in_beat_t  in_beat_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output out_beat_t out_beat_o,
  input  logic      out_stall_i
);

  logic   q_full, q_empty, push, pop, in_accept;
  group_t push_group, pop_group;

  // Stall depends only on the queue, never on in_valid_i.
  assign in_stall_o = q_full;

  b64enc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_beat_i    (in_beat_i),
    .in_accept_o  (in_accept),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_group_o (push_group)
  );

  b64enc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push && in_accept),
    .push_group_i (push_group),
    .pop_i        (pop),
    .pop_group_o  (pop_group),
    .full_o       (q_full),
    .empty_o      (q_empty)
  );

  b64enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_group_i   (pop_group),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_beat_o  (out_beat_o),
    .out_stall_i (out_stall_i)
  );

endmodule
